/* src/mtm_pkg.sv */
`default_nettype none

package mtm_pkg;

  localparam int MAX_TEMPLATES_DEF = 32;
  localparam int PATTERN_BITS_DEF  = 32;

  localparam int ACTIVE_W = 6;
  localparam int RATIO_W  = 4;
  localparam int HOLD_W   = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam int SAMPLE_W = 32;
  localparam int SLOT_W   = 5;
  localparam int CODE_W   = 8;
  localparam int OUT_CNT_W = 6;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 32;

  localparam logic [HOLD_W-1:0] REPEAT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_COUNT = 2'd0,
    REG_ACCEPT_NUM   = 2'd1,
    REG_ACCEPT_DEN   = 2'd2,
    REG_HOLD_COUNT   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } item_cmd_e;

  typedef struct packed {
    logic start;
    logic wr;
    logic rd;
    logic chk;
    logic first;
    logic fin;
    logic fin_load;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic out_busy;
  } dp_status_t;

  // Bits are summed in a balanced tree of pairwise adds.
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [1:0] s2  [32];
    logic [2:0] s4  [16];
    logic [3:0] s8  [8];
    logic [4:0] s16 [4];
    logic [5:0] s32 [2];
    for (int k = 0; k < 32; k++) begin
      s2[k] = 2'(v[2*k]) + 2'(v[2*k+1]);
    end
    for (int k = 0; k < 16; k++) begin
      s4[k] = 3'(s2[2*k]) + 3'(s2[2*k+1]);
    end
    for (int k = 0; k < 8; k++) begin
      s8[k] = 4'(s4[2*k]) + 4'(s4[2*k+1]);
    end
    for (int k = 0; k < 4; k++) begin
      s16[k] = 5'(s8[2*k]) + 5'(s8[2*k+1]);
    end
    for (int k = 0; k < 2; k++) begin
      s32[k] = 6'(s16[2*k]) + 6'(s16[2*k+1]);
    end
    return 7'(s32[0]) + 7'(s32[1]);
  endfunction

endpackage

`default_nettype wire

/* src/mtm_regs.sv */
`default_nettype none

module mtm_regs
  import mtm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output logic      [ACTIVE_W-1:0]  active_count_o,
  output logic      [RATIO_W-1:0]   accept_num_o,
  output logic      [RATIO_W-1:0]   accept_den_o,
  output logic      [HOLD_W-1:0]    hold_count_o
);

  logic [ACTIVE_W-1:0] active_q;
  logic [RATIO_W-1:0]  num_q;
  logic [RATIO_W-1:0]  den_q;
  logic [HOLD_W-1:0]   hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      num_q    <= 4'd3;
      den_q    <= 4'd10;
      hold_q   <= 8'd6;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_COUNT: active_q <= cfg_data_i[ACTIVE_W-1:0];
        REG_ACCEPT_NUM:   num_q    <= cfg_data_i[RATIO_W-1:0];
        REG_ACCEPT_DEN:   den_q    <= cfg_data_i[RATIO_W-1:0];
        REG_HOLD_COUNT:   hold_q   <= cfg_data_i[HOLD_W-1:0];
        default:          active_q <= active_q;
      endcase
    end
  end

  assign active_count_o = active_q;
  assign accept_num_o   = num_q;
  assign accept_den_o   = den_q;
  assign hold_count_o   = hold_q;

endmodule

`default_nettype wire

/* src/mtm_ctrl.sv */
`default_nettype none

module mtm_ctrl
  import mtm_pkg::*;
#(
  parameter int MAX_TEMPLATES = MAX_TEMPLATES_DEF,
  parameter int AW = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_cmd_i,
  output logic                     in_ready_o,
  input  wire logic [ACTIVE_W-1:0] active_count_i,
  input  wire dp_status_t          status_i,
  output dp_cmd_t                  cmd_o,
  output logic      [AW-1:0]       rd_addr_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [ACTIVE_W-1:0] cnt_q;
  logic [ACTIVE_W-1:0] num_q;
  logic                load_q;
  logic [ACTIVE_W-1:0] num_d;
  logic                accept;
  logic                last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (32'(active_count_i) > 32'(MAX_TEMPLATES)) begin
      num_d = ACTIVE_W'(MAX_TEMPLATES);
    end else begin
      num_d = active_count_i;
    end
  end

  assign last      = ({1'b0, cnt_q} + 7'd1) >= {1'b0, num_q};
  assign rd_addr_o = AW'(cnt_q);

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = accept && (item_cmd_e'(in_cmd_i) == CMD_SAMPLE);
    cmd_o.wr       = accept && (item_cmd_e'(in_cmd_i) == CMD_LOAD);
    cmd_o.rd       = (state_q == ST_SCAN);
    cmd_o.chk      = (cnt_q < num_q);
    cmd_o.first    = (cnt_q == '0);
    cmd_o.fin      = (state_q == ST_FIN) && !status_i.out_busy;
    cmd_o.fin_load = load_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      num_q   <= '0;
      load_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            num_q <= num_d;
            if (item_cmd_e'(in_cmd_i) == CMD_LOAD) begin
              load_q  <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              load_q  <= 1'b0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          priority if (status_i.found) begin
            state_q <= ST_FIN;
          end else if (last) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/mtm_dp.sv */
`default_nettype none

module mtm_dp
  import mtm_pkg::*;
#(
  parameter int MAX_TEMPLATES = MAX_TEMPLATES_DEF,
  parameter int PATTERN_BITS  = PATTERN_BITS_DEF,
  parameter int AW = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output dp_status_t                 status_o,
  input  wire logic [SAMPLE_W-1:0]   sensor_bits_i,
  input  wire logic [SLOT_W-1:0]     entry_index_i,
  input  wire logic [SAMPLE_W-1:0]   entry_bits_i,
  input  wire logic [SAMPLE_W-1:0]   entry_mask_i,
  input  wire logic [CODE_W-1:0]     entry_code_i,
  input  wire logic [RATIO_W-1:0]    accept_num_i,
  input  wire logic [RATIO_W-1:0]    accept_den_i,
  input  wire logic [HOLD_W-1:0]     hold_count_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [OUT_DATA_W-1:0] out_data_o
);

  localparam int PW  = PATTERN_BITS;
  localparam int CW  = $clog2(PATTERN_BITS + 1);
  localparam int MW  = 2 * CW;
  localparam int AWX = CW + RATIO_W;

  logic [PW-1:0]     pat_mem [MAX_TEMPLATES];
  logic [PW-1:0]     care_mem [MAX_TEMPLATES];
  logic [CODE_W-1:0] sym_mem [MAX_TEMPLATES];

  logic [PW-1:0]     pat_q;
  logic [PW-1:0]     care_q;
  logic [CODE_W-1:0] sym_q;
  logic [AW-1:0]     idx_q;
  logic              chk_q;
  logic              first_q;

  logic [PW-1:0]     sample_q;
  logic [AW-1:0]     best_q;
  logic [CW-1:0]     bx_q;
  logic [CW-1:0]     bm_q;
  logic [CODE_W-1:0] code_q;
  logic              found_q;

  logic [AW-1:0]     held_idx_q;
  logic              held_valid_q;
  logic [HOLD_W-1:0] rep_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [PW-1:0] diff;
  logic [CW-1:0] mx;
  logic [CW-1:0] mm;
  logic [MW-1:0] lhs;
  logic [MW-1:0] rhs;
  logic          do_cmp;
  logic          exact;
  logic          better;

  logic [AWX-1:0]    acc_lhs;
  logic [AWX-1:0]    acc_rhs;
  logic              acc;
  logic              same;
  logic              bump;
  logic [HOLD_W-1:0] rep_inc;
  logic              emit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (32'(entry_index_i) < 32'(MAX_TEMPLATES))) begin
      pat_mem[AW'(entry_index_i)]  <= PW'(entry_bits_i);
      care_mem[AW'(entry_index_i)] <= PW'(entry_mask_i);
      sym_mem[AW'(entry_index_i)]  <= entry_code_i;
    end
    if (cmd_i.rd) begin
      pat_q  <= pat_mem[rd_addr_i];
      care_q <= care_mem[rd_addr_i];
      sym_q  <= sym_mem[rd_addr_i];
      idx_q  <= rd_addr_i;
    end
  end

  assign do_cmp = chk_q && !found_q;
  assign diff   = (sample_q ^ pat_q) & care_q;
  assign exact  = (diff == '0);
  assign mx     = CW'(popcount64(64'(diff)));
  assign mm     = CW'(popcount64(64'(care_q)));
  assign lhs    = MW'(mx) * MW'(bm_q);
  assign rhs    = MW'(bx_q) * MW'(mm);
  assign better = lhs < rhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q   <= 1'b0;
      first_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      chk_q   <= cmd_i.rd && cmd_i.chk;
      first_q <= cmd_i.rd && cmd_i.first;
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (do_cmp && exact) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sample_q <= PW'(sensor_bits_i);
      best_q   <= '0;
      bx_q     <= CW'(1);
      bm_q     <= CW'(1);
    end else begin
      if (first_q) begin
        code_q <= sym_q;
      end
      if (do_cmp && exact) begin
        best_q <= idx_q;
        bx_q   <= '0;
        bm_q   <= CW'(1);
        code_q <= sym_q;
      end else if (do_cmp && better) begin
        best_q <= idx_q;
        bx_q   <= mx;
        bm_q   <= mm;
        code_q <= sym_q;
      end
    end
  end

  assign acc_lhs = AWX'(bx_q) * AWX'(accept_den_i);
  assign acc_rhs = AWX'(accept_num_i) * AWX'(bm_q);
  assign acc     = acc_lhs < acc_rhs;
  assign same    = held_valid_q && (held_idx_q == best_q);
  assign bump    = acc && same && (rep_q != REPEAT_MAX);
  assign rep_inc = rep_q + 8'd1;
  assign emit    = bump && (rep_inc == hold_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_idx_q   <= '0;
      held_valid_q <= 1'b1;
      rep_q        <= '0;
    end else if (cmd_i.fin && !cmd_i.fin_load) begin
      if (acc) begin
        if (same) begin
          if (bump) begin
            rep_q <= rep_inc;
          end
        end else begin
          held_idx_q   <= best_q;
          held_valid_q <= 1'b1;
          rep_q        <= '0;
        end
      end else begin
        held_valid_q <= 1'b0;
        rep_q        <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (cmd_i.fin_load) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {5'd0, emit, acc, OUT_CNT_W'(bm_q), OUT_CNT_W'(bx_q), code_q,
                       SLOT_W'(best_q)};
      end
    end
  end

  assign status_o.found    = found_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

`default_nettype wire

/* src/masked_template_match_with_hold.sv */
// Channel  Dir  Signals                 Contents
// s_axis   in   tvalid tready tdata     sample or template load, one item per transfer
//                      tuser            cmd (1 = load template)
// m_axis   out  tvalid tready tdata     one result per accepted item
// cfg      in   we idx data             register writes, no read-back
//
// A sample is scanned over the active templates (at least one is read), then passes
// drain and finish; an early exact match goes straight to finish. The single template
// memory read port compares one template per cycle. A load writes its template, then
// finishes. Reset idles control, sets hold to index 0 valid; templates are not
// cleared. A stalled output holds its result while the next item is taken in.
`default_nettype none

module masked_template_match_with_hold
  import mtm_pkg::*;
#(
  parameter int MAX_TEMPLATES = MAX_TEMPLATES_DEF,
  parameter int PATTERN_BITS  = PATTERN_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // sensor_bits[31:0], entry_index[36:32], entry_bits[68:37], entry_mask[100:69],
  // entry_code[108:101], zero fill [111:109]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // cmd[0]
  input  wire logic                  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // best_index[4:0], best_code[12:5], mismatch_count[18:13], care_count[24:19],
  // accepted[25], emit[26], zero fill [31:27]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int AW = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;

  logic [ACTIVE_W-1:0] active_count;
  logic [RATIO_W-1:0]  accept_num;
  logic [RATIO_W-1:0]  accept_den;
  logic [HOLD_W-1:0]   hold_count;
  dp_cmd_t             dp_cmd;
  dp_status_t          dp_status;
  logic [AW-1:0]       rd_addr;

  mtm_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .active_count_o (active_count),
    .accept_num_o   (accept_num),
    .accept_den_o   (accept_den),
    .hold_count_o   (hold_count)
  );

  mtm_ctrl #(
    .MAX_TEMPLATES (MAX_TEMPLATES),
    .AW            (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_cmd_i       (s_axis_tuser_i),
    .in_ready_o     (s_axis_tready_o),
    .active_count_i (active_count),
    .status_i       (dp_status),
    .cmd_o          (dp_cmd),
    .rd_addr_o      (rd_addr)
  );

  mtm_dp #(
    .MAX_TEMPLATES (MAX_TEMPLATES),
    .PATTERN_BITS  (PATTERN_BITS),
    .AW            (AW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .rd_addr_i     (rd_addr),
    .status_o      (dp_status),
    .sensor_bits_i (s_axis_tdata_i[31:0]),
    .entry_index_i (s_axis_tdata_i[36:32]),
    .entry_bits_i  (s_axis_tdata_i[68:37]),
    .entry_mask_i  (s_axis_tdata_i[100:69]),
    .entry_code_i  (s_axis_tdata_i[108:101]),
    .accept_num_i  (accept_num),
    .accept_den_i  (accept_den),
    .hold_count_i  (hold_count),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
